FILE: hw/rtl/bac_pkg.sv
// Shared types and codes for the bridge augmentation counter.
package bac_pkg;

	localparam logic CMD_ADD     = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_B_RD,
		ST_B_EDGE,
		ST_B_X,
		ST_B_YRD,
		ST_B_Y,
		ST_R_RD,
		ST_R_CHK,
		ST_START,
		ST_STEP,
		ST_ADJ,
		ST_VIS,
		ST_POP,
		ST_P_RD,
		ST_P,
		ST_ROOT_END,
		ST_PD_RD,
		ST_PD,
		ST_D_START,
		ST_D_BRD,
		ST_D_LRD,
		ST_D_CRD,
		ST_D_UPD,
		ST_S_RD,
		ST_S_ACC,
		ST_FIN
	} state_t;

endpackage

FILE: hw/rtl/bac_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface bac_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] node_a;
	logic [7:0] node_b;
	modport source (output valid, cmd, node_a, node_b, input ready);
	modport sink (input valid, cmd, node_a, node_b, output ready);
endinterface

interface bac_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] edges_needed;
	logic [7:0] bridge_count;
	logic [8:0] component_count;
	logic       status;
	modport source (output valid, edges_needed, bridge_count, component_count, status,
		input ready);
	modport sink (input valid, edges_needed, bridge_count, component_count, status,
		output ready);
endinterface

interface bac_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] node_count;
	modport source (output valid, node_count, input ready);
	modport sink (input valid, node_count, output ready);
endinterface

FILE: hw/rtl/bridge_augmentation_counter_core.sv
// Top level: edge store, graph walk sequencer and component degree tally.
// Add requests are accepted back to back while idle.
// A compute request clears the node tables, builds the adjacency lists (skipping bad edges),
// checks each node as a root, walks each tree and labels its nodes at each bridge and root,
// tallies the degree of each bridge's end components and sums over the components.
// The block is not ready while a compute runs; the result waits in an output register.
// arst_n clears control state: empty edge store, no drop flag, node_count = 1.
module bridge_augmentation_counter_core
	import bac_pkg::*;
#(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 1024
) (
	input logic clk,
	input logic arst_n,
	bac_req_if.sink req,
	bac_rsp_if.source rsp,
	bac_cfg_if.sink cfg
);

	localparam int NI = $clog2(MAX_NODES);
	localparam int TW = $clog2(MAX_NODES + 1);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int SA = $clog2(2 * MAX_EDGES);
	localparam int SW = $clog2(2 * MAX_EDGES + 1);
	localparam logic [TW-1:0] NO_PARENT = TW'(MAX_NODES);

	state_t state_q, state_d;

	logic [8:0]    node_count_q;
	logic [EW-1:0] edge_total_q, ei_q;
	logic          dropped_q, status_q;
	logic [TW-1:0] i_q, vc_q, ssp_q, psp_q, comps_q, bridges_q;
	logic [SW-1:0] slots_q, cur_e_q;
	logic [15:0]   xy_q;
	logic [NI-1:0] cur_u_q, st_node_q, v_q, u_q;
	logic [TW-1:0] cur_low_q, cur_par_q, st_par_q, ulow_q;
	logic          mode_all_q, k_q;
	logic [TW-1:0] bi_q, c_q, si_q;
	logic [TW:0]   sum_q;
	logic          out_valid_q;
	logic [8:0]    edges_needed_q;
	logic [7:0]    bridge_count_q;
	logic [8:0]    component_count_q;
	logic          out_status_q;

	logic [TW-1:0] n_eff;
	logic          in_acc, last_root, fin_go, bad_edge, is_bridge, pend_done;
	logic [TW:0]   answer;

	// memories
	logic [15:0]     edge_mem [MAX_EDGES];
	logic [SW-1:0]   head_mem [MAX_NODES];
	logic [NI-1:0]   tgt_mem  [2*MAX_EDGES];
	logic [SW-1:0]   nxt_mem  [2*MAX_EDGES];
	logic [TW-1:0]   disc_mem [MAX_NODES];
	logic [TW-1:0]   low_mem  [MAX_NODES];
	logic [TW-1:0]   par_mem  [MAX_NODES];
	logic [SW-1:0]   cur_mem  [MAX_NODES];
	logic [TW-1:0]   lab_mem  [MAX_NODES];
	logic [NI-1:0]   stk_mem  [MAX_NODES];
	logic [NI-1:0]   pend_mem [MAX_NODES];
	logic [2*NI-1:0] bl_mem   [MAX_NODES];
	logic [1:0]      deg_mem  [MAX_NODES+1];

	logic [15:0]     edge_rd_q;
	logic [SW-1:0]   head_rd_q, nxt_rd_q, cur_rd_q;
	logic [NI-1:0]   tgt_rd_q, stk_rd_q, pend_rd_q;
	logic [TW-1:0]   disc_rd_q, low_rd_q, par_rd_q, lab_rd_q;
	logic [2*NI-1:0] bl_rd_q;
	logic [1:0]      deg_rd_q;

	logic            edge_we, head_we, tgt_we, nxt_we, disc_we, low_we, par_we, cur_we;
	logic            lab_we, stk_we, pend_we, bl_we, deg_we;
	logic [EA-1:0]   edge_wa, edge_ra;
	logic [NI-1:0]   head_wa, head_ra, disc_wa, disc_ra, low_wa, low_ra, par_wa, nd_ra;
	logic [NI-1:0]   cur_wa, lab_wa, lab_ra, stk_wa, stk_ra, pend_wa, pend_ra, bl_wa;
	logic [SA-1:0]   slot_wa, slot_ra;
	logic [TW-1:0]   deg_wa, deg_ra;
	logic [SW-1:0]   head_wd, nxt_wd, cur_wd;
	logic [NI-1:0]   tgt_wd, stk_wd;
	logic [TW-1:0]   disc_wd, low_wd, par_wd, lab_wd;
	logic [2*NI-1:0] bl_wd;
	logic [1:0]      deg_wd;

	always_comb begin
		if (node_count_q == 9'd0) begin
			n_eff = TW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_eff = TW'(MAX_NODES);
		end else begin
			n_eff = TW'(node_count_q);
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = req.valid && req.ready;
	assign last_root = (i_q == n_eff - TW'(1));
	assign fin_go    = !out_valid_q || rsp.ready;
	assign bad_edge  = (32'(edge_rd_q[7:0]) >= 32'(n_eff)) || (32'(edge_rd_q[15:8]) >= 32'(n_eff));
	assign is_bridge = ulow_q > disc_rd_q;
	assign pend_done = (!mode_all_q && pend_rd_q == u_q) || (psp_q == TW'(1));
	assign answer    = (comps_q == TW'(1)) ? '0 : ((sum_q + (TW+1)'(1)) >> 1);

	assign rsp.valid           = out_valid_q;
	assign rsp.edges_needed    = edges_needed_q;
	assign rsp.bridge_count    = bridge_count_q;
	assign rsp.component_count = component_count_q;
	assign rsp.status          = out_status_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_acc && req.cmd == CMD_COMPUTE) state_d = ST_CLR;
			ST_CLR:      if (last_root) state_d = ST_B_RD;
			ST_B_RD:     state_d = (ei_q == edge_total_q) ? ST_R_RD : ST_B_EDGE;
			ST_B_EDGE:   state_d = bad_edge ? ST_B_RD : ST_B_X;
			ST_B_X:      state_d = ST_B_YRD;
			ST_B_YRD:    state_d = ST_B_Y;
			ST_B_Y:      state_d = ST_B_RD;
			ST_R_RD:     state_d = ST_R_CHK;
			ST_R_CHK: begin
				if (disc_rd_q == '0) state_d = ST_START;
				else state_d = last_root ? ST_D_START : ST_R_RD;
			end
			ST_START:    state_d = ST_STEP;
			ST_STEP:     state_d = (cur_e_q != '0) ? ST_ADJ : ST_POP;
			ST_ADJ:      state_d = (32'(tgt_rd_q) >= 32'(n_eff)) ? ST_STEP : ST_VIS;
			ST_VIS:      state_d = (disc_rd_q == '0) ? ST_START : ST_STEP;
			ST_POP:      state_d = (ssp_q == TW'(1)) ? ST_ROOT_END : ST_P_RD;
			ST_P_RD:     state_d = ST_P;
			ST_P:        state_d = is_bridge ? ST_PD_RD : ST_STEP;
			ST_ROOT_END: begin
				if (psp_q != '0) state_d = ST_PD_RD;
				else state_d = last_root ? ST_D_START : ST_R_RD;
			end
			ST_PD_RD:    state_d = ST_PD;
			ST_PD: begin
				if (!pend_done) state_d = ST_PD_RD;
				else if (!mode_all_q) state_d = ST_STEP;
				else state_d = last_root ? ST_D_START : ST_R_RD;
			end
			ST_D_START:  state_d = (comps_q == TW'(1)) ? ST_FIN : ST_D_BRD;
			ST_D_BRD:    state_d = (bi_q >= bridges_q) ? ST_S_RD : ST_D_LRD;
			ST_D_LRD:    state_d = ST_D_CRD;
			ST_D_CRD:    state_d = ST_D_UPD;
			ST_D_UPD:    state_d = k_q ? ST_D_BRD : ST_D_LRD;
			ST_S_RD:     state_d = (si_q > comps_q) ? ST_FIN : ST_S_ACC;
			ST_S_ACC:    state_d = ST_S_RD;
			ST_FIN:      if (fin_go) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		edge_we = 1'b0; head_we = 1'b0; tgt_we = 1'b0; nxt_we = 1'b0; disc_we = 1'b0;
		low_we = 1'b0; par_we = 1'b0; cur_we = 1'b0; lab_we = 1'b0; stk_we = 1'b0;
		pend_we = 1'b0; bl_we = 1'b0; deg_we = 1'b0;
		edge_wa = EA'(edge_total_q);
		edge_ra = EA'(ei_q);
		head_wa = '0; head_ra = '0; head_wd = '0;
		slot_wa = SA'(slots_q); slot_ra = SA'(cur_e_q - SW'(1));
		tgt_wd = '0; nxt_wd = head_rd_q;
		disc_wa = '0; disc_ra = '0; disc_wd = '0;
		low_wa = cur_u_q; low_ra = '0; low_wd = cur_low_q;
		par_wa = st_node_q; par_wd = st_par_q;
		nd_ra = stk_rd_q;
		cur_wa = cur_u_q; cur_wd = cur_e_q;
		lab_wa = pend_rd_q; lab_wd = comps_q;
		lab_ra = k_q ? bl_rd_q[2*NI-1:NI] : bl_rd_q[NI-1:0];
		stk_wa = NI'(ssp_q); stk_wd = st_node_q;
		stk_ra = NI'(ssp_q - TW'(1));
		pend_wa = NI'(psp_q); pend_ra = NI'(psp_q - TW'(1));
		bl_wa = NI'(bridges_q); bl_wd = {u_q, stk_rd_q};
		deg_wa = c_q; deg_ra = si_q; deg_wd = deg_rd_q + 2'd1;
		unique case (state_q)
			// a full store takes no write
			ST_IDLE: edge_we = in_acc && req.cmd == CMD_ADD && 32'(edge_total_q) < MAX_EDGES;
			ST_CLR: begin
				head_we = 1'b1; head_wa = NI'(i_q);
				disc_we = 1'b1; disc_wa = NI'(i_q);
				deg_we = 1'b1; deg_wa = i_q + TW'(1); deg_wd = 2'd0;
			end
			ST_B_EDGE: head_ra = NI'(edge_rd_q[7:0]);
			ST_B_X: begin
				tgt_we = 1'b1; nxt_we = 1'b1; tgt_wd = NI'(xy_q[15:8]);
				head_we = 1'b1; head_wa = NI'(xy_q[7:0]); head_wd = slots_q + SW'(1);
			end
			ST_B_YRD: head_ra = NI'(xy_q[15:8]);
			ST_B_Y: begin
				tgt_we = 1'b1; nxt_we = 1'b1; tgt_wd = NI'(xy_q[7:0]);
				head_we = 1'b1; head_wa = NI'(xy_q[15:8]); head_wd = slots_q + SW'(1);
			end
			ST_R_RD: disc_ra = NI'(i_q);
			ST_R_CHK: head_ra = NI'(i_q);
			ST_START: begin
				disc_we = 1'b1; disc_wa = st_node_q; disc_wd = vc_q + TW'(1);
				low_we = 1'b1; low_wa = st_node_q; low_wd = vc_q + TW'(1);
				par_we = 1'b1; stk_we = 1'b1; pend_we = 1'b1;
			end
			ST_ADJ: begin
				disc_ra = tgt_rd_q; low_ra = tgt_rd_q;
			end
			ST_VIS: begin
				// park the current node before descending
				cur_we = (disc_rd_q == '0);
				low_we = (disc_rd_q == '0);
				head_ra = v_q;
			end
			ST_POP: begin
				low_we = 1'b1;
				stk_ra = NI'(ssp_q - TW'(2));
			end
			ST_P_RD: begin
				disc_ra = stk_rd_q; low_ra = stk_rd_q;
			end
			ST_P: bl_we = is_bridge;
			ST_PD: lab_we = 1'b1;
			ST_D_CRD: deg_ra = lab_rd_q;
			ST_D_UPD: deg_we = (deg_rd_q < 2'd2);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_wa] <= {req.node_b, req.node_a};
		edge_rd_q <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (tgt_we) tgt_mem[slot_wa] <= tgt_wd;
		tgt_rd_q <= tgt_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[slot_wa] <= nxt_wd;
		nxt_rd_q <= nxt_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		disc_rd_q <= disc_mem[disc_ra];
	end

	always_ff @(posedge clk) begin
		if (low_we) low_mem[low_wa] <= low_wd;
		low_rd_q <= low_mem[low_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= par_wd;
		par_rd_q <= par_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		cur_rd_q <= cur_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (lab_we) lab_mem[lab_wa] <= lab_wd;
		lab_rd_q <= lab_mem[lab_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_wa] <= stk_wd;
		pend_rd_q <= pend_mem[pend_ra];
	end

	always_ff @(posedge clk) begin
		if (bl_we) bl_mem[bl_wa] <= bl_wd;
		bl_rd_q <= bl_mem[NI'(bi_q)];
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		deg_rd_q <= deg_mem[deg_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 9'd1;
			edge_total_q <= '0;
			dropped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) node_count_q <= cfg.node_count;
			if (state_q == ST_FIN && fin_go) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && in_acc && req.cmd == CMD_ADD) begin
				if (32'(edge_total_q) >= MAX_EDGES || 32'(req.node_a) >= 32'(n_eff)
						|| 32'(req.node_b) >= 32'(n_eff)) begin
					dropped_q <= 1'b1;
				end else begin
					edge_total_q <= edge_total_q + EW'(1);
				end
			end
			if (state_q == ST_FIN && fin_go) begin
				edge_total_q <= '0;
				dropped_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				status_q <= dropped_q;
				i_q <= '0; ei_q <= '0; slots_q <= '0; vc_q <= '0;
				ssp_q <= '0; psp_q <= '0; comps_q <= '0; bridges_q <= '0;
			end
			ST_CLR: i_q <= last_root ? '0 : i_q + TW'(1);
			ST_B_EDGE: begin
				xy_q <= edge_rd_q;
				if (bad_edge) begin
					status_q <= 1'b1;
					ei_q <= ei_q + EW'(1);
				end
			end
			ST_B_X: slots_q <= slots_q + SW'(1);
			ST_B_Y: begin
				slots_q <= slots_q + SW'(1);
				ei_q <= ei_q + EW'(1);
			end
			ST_R_CHK: begin
				st_node_q <= NI'(i_q);
				st_par_q <= NO_PARENT;
				if (disc_rd_q != '0 && !last_root) i_q <= i_q + TW'(1);
			end
			ST_START: begin
				vc_q <= vc_q + TW'(1);
				cur_u_q <= st_node_q;
				cur_e_q <= head_rd_q;
				cur_low_q <= vc_q + TW'(1);
				cur_par_q <= st_par_q;
				ssp_q <= ssp_q + TW'(1);
				psp_q <= psp_q + TW'(1);
			end
			ST_ADJ: begin
				v_q <= tgt_rd_q;
				cur_e_q <= nxt_rd_q;
			end
			ST_VIS: begin
				st_node_q <= v_q;
				st_par_q <= TW'(cur_u_q);
				// an edge back to the tree parent never lowers low
				if (disc_rd_q != '0 && TW'(v_q) != cur_par_q && low_rd_q < cur_low_q)
					cur_low_q <= low_rd_q;
			end
			ST_POP: begin
				u_q <= cur_u_q;
				ulow_q <= cur_low_q;
				ssp_q <= ssp_q - TW'(1);
			end
			ST_P: begin
				cur_u_q <= stk_rd_q;
				cur_par_q <= par_rd_q;
				cur_e_q <= cur_rd_q;
				cur_low_q <= (ulow_q < low_rd_q) ? ulow_q : low_rd_q;
				mode_all_q <= 1'b0;
				if (is_bridge) begin
					bridges_q <= bridges_q + TW'(1);
					comps_q <= comps_q + TW'(1);
				end
			end
			ST_ROOT_END: begin
				comps_q <= comps_q + TW'(1);
				mode_all_q <= 1'b1;
				if (psp_q == '0 && !last_root) i_q <= i_q + TW'(1);
			end
			ST_PD: begin
				psp_q <= psp_q - TW'(1);
				if (pend_done && mode_all_q && !last_root) i_q <= i_q + TW'(1);
			end
			ST_D_START: begin
				bi_q <= '0; k_q <= 1'b0; sum_q <= '0; si_q <= TW'(1);
			end
			ST_D_CRD: c_q <= lab_rd_q;
			ST_D_UPD: begin
				k_q <= !k_q;
				if (k_q) bi_q <= bi_q + TW'(1);
			end
			ST_S_ACC: begin
				if (deg_rd_q == 2'd0) sum_q <= sum_q + (TW+1)'(2);
				else if (deg_rd_q == 2'd1) sum_q <= sum_q + (TW+1)'(1);
				si_q <= si_q + TW'(1);
			end
			ST_FIN: begin
				if (fin_go) begin
					edges_needed_q <= 9'(answer);
					bridge_count_q <= 8'(bridges_q);
					component_count_q <= 9'(comps_q);
					out_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ssp_q) <= MAX_NODES) && (32'(psp_q) <= MAX_NODES))
		else $error("search stack overrun");

	a_compute_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.cmd == CMD_COMPUTE) |=> (state_q == ST_CLR))
		else $error("compute request did not start clearing");

	a_comps_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (comps_q != '0))
		else $error("no component found at finish");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(edge_total_q) <= MAX_EDGES)
		else $error("edge store overfilled");

endmodule

FILE: verif/bac_checker.sv
// Checker: watches request, result and config channels, predicts results and compares.
module bac_checker
	import bac_pkg::*;
(
	input logic clk,
	bac_req_if req,
	bac_rsp_if rsp,
	bac_cfg_if cfg,
	output int fail_count,
	output int pending_count,
	output int result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 256;
	localparam int EDGES = 1024;

	typedef struct packed {
		logic [8:0] edges_needed;
		logic [7:0] bridge_count;
		logic [8:0] component_count;
		logic       status;
	} answer_t;

	answer_t answer_q[$];
	logic [8:0] node_cfg;
	logic [15:0] edge_store[EDGES];
	int edge_num;
	bit dropped;

	function automatic int clamped_nodes();
		int n;
		n = node_cfg;
		if (n == 0) n = 1;
		if (n > NODES) n = NODES;
		return n;
	endfunction

	function automatic answer_t solve_graph();
		int n, slots, sp, pp, comps, bridges, sum, u, e, v, p, w, c;
		int head[NODES], nxt[2*EDGES], tgt[2*EDGES];
		int disc[NODES], low[NODES], par[NODES], cur[NODES], lbl[NODES];
		int stk[NODES], pend[NODES], br_a[NODES], br_b[NODES], deg[NODES+1];
		int clk_v, x, y;
		answer_t r;
		n = clamped_nodes();
		slots = 0; sp = 0; pp = 0; comps = 0; bridges = 0; sum = 0; clk_v = 0;
		r.status = dropped;
		for (int i = 0; i < NODES; i++) begin
			head[i] = 0;
			disc[i] = 0;
		end
		for (int i = 0; i <= NODES; i++) deg[i] = 0;
		for (int i = 0; i < edge_num; i++) begin
			x = edge_store[i][7:0];
			y = edge_store[i][15:8];
			if (x >= n || y >= n) begin
				r.status = 1'b1;
				continue;
			end
			tgt[slots] = y; nxt[slots] = head[x]; head[x] = slots + 1; slots++;
			tgt[slots] = x; nxt[slots] = head[y]; head[y] = slots + 1; slots++;
		end
		for (int i = 0; i < n; i++) begin
			if (disc[i] != 0) continue;
			clk_v++;
			disc[i] = clk_v; low[i] = clk_v; par[i] = NODES; cur[i] = head[i];
			stk[sp] = i; sp++;
			pend[pp] = i; pp++;
			while (sp > 0) begin
				u = stk[sp-1];
				e = cur[u];
				if (e != 0) begin
					v = tgt[e-1];
					cur[u] = nxt[e-1];
					if (disc[v] == 0) begin
						clk_v++;
						disc[v] = clk_v; low[v] = clk_v; par[v] = u; cur[v] = head[v];
						stk[sp] = v; sp++;
						pend[pp] = v; pp++;
					end else if (v != par[u] && low[v] < low[u]) low[u] = low[v];
				end else begin
					sp--;
					if (sp > 0) begin
						p = stk[sp-1];
						if (low[u] < low[p]) low[p] = low[u];
						if (low[u] > disc[p]) begin
							br_a[bridges] = p; br_b[bridges] = u;
							bridges++; comps++;
							while (pp > 0) begin
								pp--;
								w = pend[pp];
								lbl[w] = comps;
								if (w == u) break;
							end
						end
					end
				end
			end
			comps++;
			while (pp > 0) begin
				pp--;
				lbl[pend[pp]] = comps;
			end
		end
		if (comps != 1) begin
			for (int i = 0; i < bridges; i++) begin
				c = lbl[br_a[i]];
				if (deg[c] < 2) deg[c]++;
				c = lbl[br_b[i]];
				if (deg[c] < 2) deg[c]++;
			end
			for (int i = 1; i <= comps; i++)
				if (deg[i] == 0) sum += 2;
				else if (deg[i] == 1) sum += 1;
		end
		r.edges_needed = (comps == 1) ? 9'd0 : 9'((sum + 1) / 2);
		r.bridge_count = 8'(bridges);
		r.component_count = 9'(comps);
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		node_cfg = 9'd1;
		edge_num = 0;
		dropped = 1'b0;
	end

	assign pending_count = answer_q.size();

	always @(posedge clk) begin
		answer_t got, want;
		if (cfg.valid && cfg.ready) node_cfg <= cfg.node_count;
		if (req.valid && req.ready) begin
			if (req.cmd == CMD_ADD) begin
				if (edge_num >= EDGES || req.node_a >= clamped_nodes()
						|| req.node_b >= clamped_nodes())
					dropped = 1'b1;
				else begin
					edge_store[edge_num] = {req.node_b, req.node_a};
					edge_num++;
				end
			end else begin
				answer_q = {answer_q, solve_graph()};
				edge_num = 0;
				dropped = 1'b0;
			end
		end
		if (rsp.valid && rsp.ready) begin
			got = {rsp.edges_needed, rsp.bridge_count, rsp.component_count, rsp.status};
			result_count++;
			if (answer_q.size() == 0) report("unexpected result", 1, 0);
			else begin
				want = answer_q.pop_front();
				if (got.edges_needed !== want.edges_needed)
					report("edges_needed", got.edges_needed, want.edges_needed);
				if (got.bridge_count !== want.bridge_count)
					report("bridge_count", got.bridge_count, want.bridge_count);
				if (got.component_count !== want.component_count)
					report("component_count", got.component_count, want.component_count);
				if (got.status !== want.status)
					report("status", got.status, want.status);
			end
		end
	end
endmodule

FILE: verif/bridge_augmentation_counter_core_tb.sv
// Testbench top: clock, reset, graph stimulus, config phases and verdict.
module bridge_augmentation_counter_core_tb;
	import bac_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int fail_count, pending_count, result_count;
	int item_total;
	int cur_nodes;
	bit calm;

	bac_req_if req();
	bac_rsp_if rsp();
	bac_cfg_if cfg();

	bridge_augmentation_counter_core dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	bac_checker chk (
		.clk(clk), .req(req), .rsp(rsp), .cfg(cfg),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("FAIL bridge_augmentation_counter_core");
		$finish;
	end

	// random result-side stalls in bursts
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// valid stays high after an accept; the next request or a drain replaces it
	task automatic send_request(input logic c, input logic [7:0] a, input logic [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.node_a <= a;
		req.node_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		item_total++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_nodes(input int n);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.node_count <= 9'(n);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		cur_nodes = (n == 0) ? 1 : ((n > 256) ? 256 : n);
	endtask

	function automatic logic [7:0] pick_node(input int n);
		// mostly legal endpoints, a few out of range
		if ($urandom_range(0, 40) == 0) return 8'($urandom);
		return 8'($urandom_range(0, n - 1));
	endfunction

	// a random graph: chain edges a to a+1 mixed with random pairs, some out of range, then a compute
	task automatic random_graph(input int n, input int edges);
		int a, b;
		for (int i = 0; i < edges; i++) begin
			if ($urandom_range(0, 2) == 0 && n > 1) begin
				a = $urandom_range(0, n - 2);
				b = a + 1;
			end else begin
				a = pick_node(n);
				b = pick_node(n);
			end
			send_request(CMD_ADD, 8'(a), 8'(b));
		end
		send_request(CMD_COMPUTE, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		calm = 1'b0;
		item_total = 0;
		cur_nodes = 1;
		req.valid = 1'b0; req.cmd = CMD_ADD; req.node_a = '0; req.node_b = '0;
		cfg.valid = 1'b0; cfg.node_count = 9'd1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset node count, empty graph, self loop, drops
		send_request(CMD_COMPUTE, 8'hFF, 8'hFF);
		send_request(CMD_ADD, 8'd0, 8'd0);
		send_request(CMD_ADD, 8'd0, 8'd1);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		set_nodes(0);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		set_nodes(4);
		send_request(CMD_ADD, 8'd0, 8'd1);
		send_request(CMD_ADD, 8'd1, 8'd0);
		send_request(CMD_ADD, 8'd1, 8'd2);
		send_request(CMD_ADD, 8'd2, 8'd3);
		send_request(CMD_ADD, 8'd3, 8'd1);
		send_request(CMD_ADD, 8'd3, 8'd4);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		// edges stored, then node count shrunk before compute
		send_request(CMD_ADD, 8'd0, 8'd3);
		send_request(CMD_ADD, 8'd2, 8'd1);
		set_nodes(3);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		set_nodes(511);
		send_request(CMD_ADD, 8'd255, 8'd0);
		send_request(CMD_ADD, 8'd170, 8'd85);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		// fill the edge store past capacity
		for (int i = 0; i < 1030; i++)
			send_request(CMD_ADD, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
		send_request(CMD_COMPUTE, 8'h00, 8'h00);
		set_nodes(256);
		send_request(CMD_COMPUTE, 8'h00, 8'h00);

		// random phases with various node counts, mostly small graphs
		while (item_total < 1900) begin
			case ($urandom_range(0, 4))
				0: n = $urandom_range(1, 3);
				1, 2: n = $urandom_range(2, 12);
				3: n = $urandom_range(13, 40);
				default: n = $urandom_range(0, 511);
			endcase
			set_nodes(n);
			for (int g = 0; g < 4; g++)
				random_graph(cur_nodes, $urandom_range(0, 2 * cur_nodes + 2 > 60 ?
					60 : 2 * cur_nodes + 2));
			if (item_total > 1700) calm = 1'b1;
		end

		drain_results();
		repeat (50) @(negedge clk);
		$display("run covered %0d requests and %0d graph results across node counts 0..511",
			item_total, result_count);
		if (fail_count == 0) begin
			$display("PASS bridge_augmentation_counter_core");
		end else begin
			$display("FAIL bridge_augmentation_counter_core");
		end
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/bac_pkg.sv
hw/rtl/bac_if.sv
hw/rtl/bridge_augmentation_counter_core.sv
verif/bac_checker.sv
verif/bridge_augmentation_counter_core_tb.sv
